// ----- hdl/qhd_pkg.sv -----
// Package for the quaternion heading delta block.
// Holds CORDIC angle table, angle constants, status codes and shared types.
// No dependencies.
package qhd_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int TABLE_LEN    = 24;
    localparam int N_STEPS      = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;

    // operand width: |num|,|den| at most 2^32 for any 16-bit pattern; CORDIC gain < 1.65
    localparam int VW = 36;
    localparam int AW = 26;
    localparam int DW = 27;

    localparam logic signed [AW-1:0] ANG_HALF_PI = AW'(1647099);
    localparam logic signed [DW-1:0] ANG_PI      = DW'(3294199);
    localparam logic signed [DW-1:0] ANG_TWO_PI  = DW'(6588397);
    localparam logic signed [15:0]   OUT_LIMIT   = 16'sd25736;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_GOAL   = 2'd1,
        ST_NO_POSE   = 2'd2,
        ST_UNUSED    = 2'd3
    } t_status;

    typedef struct packed {
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic signed [AW-1:0] z;
    } t_vec;

    typedef struct packed {
        t_status              status;
        logic signed [15:0]   gw, gx, gy, gz, cw, cx, cy, cz;
    } t_job;

    function automatic logic signed [AW-1:0] atan_tab(input int i);
        logic signed [AW-1:0] r;
        case (i)
            0: r = AW'(823550);   1: r = AW'(486170);   2: r = AW'(256879);
            3: r = AW'(130396);   4: r = AW'(65451);    5: r = AW'(32757);
            6: r = AW'(16383);    7: r = AW'(8192);     8: r = AW'(4096);
            9: r = AW'(2048);    10: r = AW'(1024);    11: r = AW'(512);
            12: r = AW'(256);    13: r = AW'(128);     14: r = AW'(64);
            15: r = AW'(32);     16: r = AW'(16);      17: r = AW'(8);
            18: r = AW'(4);      19: r = AW'(2);       20: r = AW'(1);
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic int atan_sum();
        int s;
        s = 0;
        for (int i = 0; i < N_STEPS; i++) s += int'(atan_tab(i));
        return s;
    endfunction

    // angle gathered by a zero vector, which always rotates the positive way
    localparam logic signed [AW-1:0] ATAN_SUM = AW'(atan_sum());

endpackage

// ----- hdl/qhd_front.sv -----
// Front end: accepts transfers, classifies presence, queues jobs (2-entry skid FIFO).
// Depends on qhd_pkg.
module qhd_front import qhd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_goal_present,
    input  logic        i_pose_present,
    input  logic signed [15:0] i_gw, i_gx, i_gy, i_gz, i_cw, i_cx, i_cy, i_cz,
    output logic        o_job_valid,
    input  logic        i_job_ready,
    output t_job        o_job
);
    t_job       r_q [2];
    logic       r_rd, r_wr;
    logic [1:0] r_cnt;
    t_job       n_job;
    logic       push, pop;

    always_comb begin
        n_job.gw = i_gw; n_job.gx = i_gx; n_job.gy = i_gy; n_job.gz = i_gz;
        n_job.cw = i_cw; n_job.cx = i_cx; n_job.cy = i_cy; n_job.cz = i_cz;
        if (!i_goal_present)      n_job.status = ST_NO_GOAL;
        else if (!i_pose_present) n_job.status = ST_NO_POSE;
        else                      n_job.status = ST_OK;
    end

    assign o_ready     = (r_cnt != 2'd2);
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = r_q[r_rd];
    assign push        = i_valid && o_ready;
    assign pop         = o_job_valid && i_job_ready;

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wr] <= n_job;
        if (!i_rst_n) begin
            r_rd <= 1'b0; r_wr <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (push) r_wr <= ~r_wr;
            if (pop)  r_rd <= ~r_rd;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end
endmodule

// ----- hdl/qhd_yaw_pipe.sv -----
// Back end: pipelined products, dual CORDIC atan2, wrap, round and clamp.
// One stage per CORDIC step; stalls as a whole when output is held. Depends on qhd_pkg.
module qhd_yaw_pipe import qhd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_job_valid,
    output logic        o_job_ready,
    input  t_job        i_job,
    output logic        o_valid,
    input  logic        i_ready,
    output logic signed [15:0] o_heading_delta,
    output logic [1:0]  o_status
);
    localparam int NS = N_STEPS + 5;

    logic    adv;
    logic    r_v [NS];
    t_status r_st[NS];

    // stage 0: products
    logic signed [31:0] r_p [2][4];
    // stage 1: operands
    logic signed [VW-1:0] r_num [2], r_den [2];
    // stage 2..: CORDIC
    t_vec r_c [2][N_STEPS+1];
    logic signed [DW-1:0] r_d;
    logic signed [15:0]   r_out;

    assign adv         = !r_v[NS-1] || i_ready;
    assign o_job_ready = adv;
    assign o_valid     = r_v[NS-1];
    assign o_status    = r_st[NS-1];
    assign o_heading_delta = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NS; s++) r_v[s] <= 1'b0;
        end else if (adv) begin
            r_v[0] <= i_job_valid;
            for (int s = 1; s < NS; s++) r_v[s] <= r_v[s-1];
        end
    end

    logic signed [15:0] qw [2], qx [2], qy [2], qz [2];
    always_comb begin
        qw[0] = i_job.gw; qx[0] = i_job.gx; qy[0] = i_job.gy; qz[0] = i_job.gz;
        qw[1] = i_job.cw; qx[1] = i_job.cx; qy[1] = i_job.cy; qz[1] = i_job.cz;
    end

    t_vec pre [2];
    always_comb begin
        for (int k = 0; k < 2; k++) begin
            pre[k].x = r_den[k]; pre[k].y = r_num[k]; pre[k].z = '0;
            if (r_den[k] < 0) begin
                if (r_num[k] >= 0) begin
                    pre[k].x = r_num[k]; pre[k].y = -r_den[k]; pre[k].z = ANG_HALF_PI;
                end else begin
                    pre[k].x = -r_num[k]; pre[k].y = r_den[k]; pre[k].z = -ANG_HALF_PI;
                end
            end else if (r_den[k] == 0 && r_num[k] == 0) begin
                pre[k].z = -ATAN_SUM;
            end
        end
    end

    logic signed [DW-1:0] dsub, dwrap;
    logic signed [DW-1:0] rsh;
    always_comb begin
        dsub = DW'(r_c[0][N_STEPS].z) - DW'(r_c[1][N_STEPS].z);
        if (dsub > ANG_PI)       dwrap = dsub - ANG_TWO_PI;
        else if (dsub < -ANG_PI) dwrap = dsub + ANG_TWO_PI;
        else                     dwrap = dsub;
        rsh = (r_d + DW'(64)) >>> 7;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_st[0] <= i_job.status;
            for (int s = 1; s < NS; s++) r_st[s] <= r_st[s-1];
            for (int k = 0; k < 2; k++) begin
                r_p[k][0] <= qw[k] * qz[k];
                r_p[k][1] <= qx[k] * qy[k];
                r_p[k][2] <= qy[k] * qy[k];
                r_p[k][3] <= qz[k] * qz[k];
                r_num[k] <= VW'(r_p[k][0]) + VW'(r_p[k][1]) <<< 1;
                r_den[k] <= (VW'(1) <<< 28) - ((VW'(r_p[k][2]) + VW'(r_p[k][3])) <<< 1);
                r_c[k][0] <= pre[k];
                for (int i = 0; i < N_STEPS; i++) begin
                    if (r_c[k][i].y >= 0) begin
                        r_c[k][i+1].x <= r_c[k][i].x + (r_c[k][i].y >>> i);
                        r_c[k][i+1].y <= r_c[k][i].y - (r_c[k][i].x >>> i);
                        r_c[k][i+1].z <= r_c[k][i].z + atan_tab(i);
                    end else begin
                        r_c[k][i+1].x <= r_c[k][i].x - (r_c[k][i].y >>> i);
                        r_c[k][i+1].y <= r_c[k][i].y + (r_c[k][i].x >>> i);
                        r_c[k][i+1].z <= r_c[k][i].z - atan_tab(i);
                    end
                end
            end
            r_d <= dwrap;
            if (r_st[NS-2] != ST_OK)          r_out <= '0;
            else if (rsh > DW'(OUT_LIMIT))    r_out <= OUT_LIMIT;
            else if (rsh < -DW'(OUT_LIMIT))   r_out <= -OUT_LIMIT;
            else                              r_out <= rsh[15:0];
        end
    end
endmodule

// ----- hdl/quaternion_heading_delta.sv -----
// Quaternion heading delta: yaw of goal minus yaw of current, wrapped to [-pi, pi], Q2.13.
// Accepts one transfer per cycle while the two-entry input queue has room; the queue feeds the
// fully pipelined CORDIC (one stage per step) plus product, operand, wrap and round stages.
// Zero-vector operands start from an angle offset that the rotations cancel, so they yield a
// yaw of zero.
// Depends on qhd_pkg, qhd_front and qhd_yaw_pipe.
module quaternion_heading_delta import qhd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_goal_present,
    input  logic        i_pose_present,
    input  logic signed [15:0] i_goal_w, i_goal_x, i_goal_y, i_goal_z,
    input  logic signed [15:0] i_current_w, i_current_x, i_current_y, i_current_z,
    output logic        o_valid,
    input  logic        i_ready,
    output logic signed [15:0] o_heading_delta,
    output logic [1:0]  o_status
);
    logic job_valid, job_ready;
    t_job job;

    qhd_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_goal_present, .i_pose_present,
        .i_gw(i_goal_w), .i_gx(i_goal_x), .i_gy(i_goal_y), .i_gz(i_goal_z),
        .i_cw(i_current_w), .i_cx(i_current_x), .i_cy(i_current_y), .i_cz(i_current_z),
        .o_job_valid(job_valid), .i_job_ready(job_ready), .o_job(job)
    );

    qhd_yaw_pipe u_back (
        .i_clk, .i_rst_n, .i_job_valid(job_valid), .o_job_ready(job_ready), .i_job(job),
        .o_valid, .i_ready, .o_heading_delta, .o_status
    );
endmodule

// ----- hdl/qhd_checker.sv -----
// Port-level checker for quaternion_heading_delta, bound to the top level.
// Depends on qhd_pkg.
module qhd_checker import qhd_pkg::*; (
    input logic i_clk, i_rst_n, o_ready, o_valid, i_ready,
    input logic signed [15:0] o_heading_delta,
    input logic [1:0] o_status
);
    a_no_code3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status != ST_UNUSED) else $error("status code 3");
    a_zero_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> o_heading_delta == 16'sd0) else $error("nonzero fail");
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_heading_delta <= OUT_LIMIT && o_heading_delta >= -OUT_LIMIT)
        else $error("range");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_heading_delta) && $stable(o_status))
        else $error("hold");
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_ready) else $error("reset valid");
endmodule

bind quaternion_heading_delta qhd_checker u_chk (.*);

// ----- tb/tb_quaternion_heading_delta.sv -----
// Testbench for quaternion_heading_delta: random and directed quaternion pairs,
// yaw difference predicted by a 64-bit CORDIC model using the block's angle table.
// Depends on qhd_pkg and the quaternion_heading_delta RTL.
module tb_quaternion_heading_delta;
    import qhd_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 64;
    localparam int RANDOM_ITEMS   = 850;

    typedef struct {
        logic        goal_present;
        logic        pose_present;
        logic [15:0] q [8];
    } t_pair;

    typedef struct {
        logic signed [15:0] delta;
        logic [1:0]         status;
    } t_heading;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic i_goal_present = 1'b0;
    logic i_pose_present = 1'b0;
    logic signed [15:0] i_goal_w = '0, i_goal_x = '0, i_goal_y = '0, i_goal_z = '0;
    logic signed [15:0] i_current_w = '0, i_current_x = '0, i_current_y = '0;
    logic signed [15:0] i_current_z = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic signed [15:0] o_heading_delta;
    logic [1:0] o_status;

    t_pair    pending_pairs[$];
    t_heading expected_headings[$];
    int  mismatches = 0;
    int  idle_cycles = 0;
    bit  stim_done = 1'b0;
    bit  quiet_tail = 1'b0;
    bit  hold_off_req = 1'b0;
    bit  pause_sender = 1'b0;
    bit  accepted_in = 1'b0;
    int  send_gap = 0;
    int  recv_gap = 0;
    int  hold_off_left = 0;

    quaternion_heading_delta dut (.*);

    always #4 i_clk = ~i_clk;

    function automatic longint yaw_angle(input logic [15:0] qw, qx, qy, qz);
        longint w, x, y, z, xv, yv, zv, xs, ys, t;
        w = longint'($signed(qw));
        x = longint'($signed(qx));
        y = longint'($signed(qy));
        z = longint'($signed(qz));
        yv = 2 * (w * z + x * y);
        xv = (longint'(1) << 28) - 2 * (y * y + z * z);
        zv = 0;
        if (xv == 0 && yv == 0) return 0;
        if (xv < 0) begin
            if (yv >= 0) begin
                t = xv; xv = yv; yv = -t; zv = 1647099;
            end else begin
                t = xv; xv = -yv; yv = t; zv = -1647099;
            end
        end
        for (int i = 0; i < N_STEPS; i++) begin
            xs = xv >>> i;
            ys = yv >>> i;
            if (yv >= 0) begin
                xv += ys; yv -= xs; zv += longint'(atan_tab(i));
            end else begin
                xv -= ys; yv += xs; zv -= longint'(atan_tab(i));
            end
        end
        return zv;
    endfunction

    function automatic t_heading predict_heading(input t_pair p);
        t_heading h;
        longint d, r;
        h.delta = '0;
        if (!p.goal_present) begin
            h.status = ST_NO_GOAL;
            return h;
        end
        if (!p.pose_present) begin
            h.status = ST_NO_POSE;
            return h;
        end
        d = yaw_angle(p.q[0], p.q[1], p.q[2], p.q[3])
          - yaw_angle(p.q[4], p.q[5], p.q[6], p.q[7]);
        if (d > 3294199) d -= 6588397;
        else if (d < -3294199) d += 6588397;
        r = (d + 64) >>> 7;
        if (r > 25736) r = 25736;
        if (r < -25736) r = -25736;
        h.delta = 16'(r);
        h.status = ST_OK;
        return h;
    endfunction

    function automatic logic [15:0] rand_comp();
        case ($urandom_range(0, 9))
            0: return 16'(16384);
            1: return 16'(-16384);
            2: return 16'h8000;
            3: return 16'h7fff;
            4: return 16'h0000;
            5, 6: return 16'($urandom);
            default: return 16'($signed($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    task automatic add_pair(input bit gp, pp, input logic [15:0] c [8]);
        t_pair p;
        p.goal_present = gp;
        p.pose_present = pp;
        p.q = c;
        pending_pairs.push_back(p);
    endtask

    task automatic add_yaw_pair(input int ga, ca);
        logic [15:0] c [8];
        c = '{16'(ga), 16'd0, 16'd0, 16'(ca), 16'(ca), 16'd0, 16'd0, 16'(ga)};
        add_pair(1'b1, 1'b1, c);
    endtask

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_valid || accepted_in) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    i_valid <= 1'b0;
                end else if (pending_pairs.size() > 0 && !pause_sender) begin
                    t_pair p;
                    p = pending_pairs.pop_front();
                    i_valid <= 1'b1;
                    i_goal_present <= p.goal_present;
                    i_pose_present <= p.pose_present;
                    i_goal_w <= p.q[0]; i_goal_x <= p.q[1];
                    i_goal_y <= p.q[2]; i_goal_z <= p.q[3];
                    i_current_w <= p.q[4]; i_current_x <= p.q[5];
                    i_current_y <= p.q[6]; i_current_z <= p.q[7];
                    if (!quiet_tail && $urandom_range(0, 7) == 0)
                        send_gap <= $urandom_range(1, 6);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (hold_off_req && hold_off_left == 0) begin
                hold_off_left <= 200;
                i_ready <= 1'b0;
            end else if (hold_off_left > 0) begin
                hold_off_left <= hold_off_left - 1;
                i_ready <= (hold_off_left == 1);
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                if (!quiet_tail && $urandom_range(0, 7) == 0)
                    recv_gap <= $urandom_range(1, 6);
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_pair p;
        t_heading e;
        accepted_in <= i_rst_n && i_valid && o_ready;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                p.goal_present = i_goal_present;
                p.pose_present = i_pose_present;
                p.q = '{i_goal_w, i_goal_x, i_goal_y, i_goal_z,
                        i_current_w, i_current_x, i_current_y, i_current_z};
                expected_headings.push_back(predict_heading(p));
            end
            if (o_valid && i_ready) begin
                if (expected_headings.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: delta %0d status %0d",
                                 o_heading_delta, o_status);
                end else begin
                    e = expected_headings.pop_front();
                    if (o_heading_delta !== e.delta || o_status !== e.status) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: delta exp %0d got %0d, status exp %0d got %0d",
                                     e.delta, o_heading_delta, e.status, o_status);
                    end
                end
            end
            if ((i_valid && o_ready) || (o_valid && i_ready) || stim_done)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_quaternion_heading_delta: FAIL");
                $finish;
            end
        end
    end

    initial begin
        logic [15:0] c [8];
        int angles [6];
        angles = '{0, 16384, -16384, 11585, -11585, 16383};
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // presence flags
        c = '{16'd16384, 16'd0, 16'd0, 16'd0, 16'd16384, 16'd0, 16'd0, 16'd0};
        add_pair(1'b0, 1'b0, c);
        add_pair(1'b0, 1'b1, c);
        add_pair(1'b1, 1'b0, c);
        add_pair(1'b1, 1'b1, c);
        // zero vectors and extremes
        c = '{default: 16'd0};
        add_pair(1'b1, 1'b1, c);
        c = '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff};
        add_pair(1'b1, 1'b1, c);
        c = '{16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff};
        add_pair(1'b1, 1'b1, c);
        // negative real axis: yaw pi (z = 1, w = 0)
        add_yaw_pair(0, 16384);
        add_yaw_pair(16384, 0);
        // wrap both ways, near +-pi
        foreach (angles[i]) add_yaw_pair(angles[i], angles[(i + 3) % 6]);
        add_yaw_pair(-1000, 1000);
        add_yaw_pair(1000, -1000);
        c = '{16'd0, 16'd16384, 16'd16384, 16'd0, 16'd0, 16'(-16384), 16'd16384, 16'd0};
        add_pair(1'b1, 1'b1, c);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            for (int k = 0; k < 8; k++) c[k] = rand_comp();
            if (n == 300) begin
                wait (pending_pairs.size() == 0);
                hold_off_req = 1'b1;
                wait (hold_off_left > 0);
                hold_off_req = 1'b0;
            end
            if (n == 500) begin
                wait (pending_pairs.size() == 0);
                pause_sender = 1'b1;
                wait (expected_headings.size() == 0 && !i_valid);
                pause_sender = 1'b0;
            end
            if (n == 700) quiet_tail = 1'b1;
            add_pair($urandom_range(0, 9) != 0, $urandom_range(0, 9) != 0, c);
        end

        wait (pending_pairs.size() == 0 && !i_valid);
        fork
            wait (expected_headings.size() == 0);
            begin
                repeat (WATCHDOG_LIMIT) @(posedge i_clk);
                $display("tb_quaternion_heading_delta: FAIL");
                $finish;
            end
        join_any
        stim_done = 1'b1;
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_headings.size() == 0)
            $display("tb_quaternion_heading_delta: PASS");
        else
            $display("tb_quaternion_heading_delta: FAIL");
        $finish;
    end
endmodule

// ----- filelist.f -----
hdl/qhd_pkg.sv
hdl/qhd_front.sv
hdl/qhd_yaw_pipe.sv
hdl/quaternion_heading_delta.sv
hdl/qhd_checker.sv
tb/tb_quaternion_heading_delta.sv
